@@ src/wbc_pkg.sv @@
// ----------------------------------------------------------------------------
// wbc_pkg
// shared types and constants of the white blob centroid steering block
// ----------------------------------------------------------------------------
package wbc_pkg;

  localparam int COL_W = 13;
  localparam int SUM_W = 35;
  localparam int CNT_W = 25;
  localparam int HALF_W = 12;
  localparam int QUO_W = 16;
  localparam int STEP_W = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // quotient widths of the two divisions: centroid < 2^13, linear < 2^16
  localparam int CENT_SHIFT = 13;
  localparam logic [STEP_W-1:0] CENT_LAST = 4'd12;
  localparam logic [STEP_W-1:0] LIN_LAST = 4'd15;

  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_WHITE_LEVEL = 2'd1;
  localparam logic [1:0] REG_ANGULAR_GAIN = 2'd2;
  localparam logic [1:0] REG_MAX_LINEAR = 2'd3;

  localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;
  localparam logic [7:0] RST_WHITE_LEVEL = 8'd255;
  localparam logic [15:0] RST_ANGULAR_GAIN = 16'd197;
  localparam logic [15:0] RST_MAX_LINEAR = 16'd32768;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_CENT,
    ST_OFFSET,
    ST_PROD,
    ST_LIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic pix;
    logic div_step;
    logic calc_offset;
    logic calc_prod;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic lin_ok;
    logic out_free;
  } sts_t;

endpackage

@@ src/wbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// wbc_ctrl
// sequencer: pixel accumulation, shared divider steps and result hand-off
// ----------------------------------------------------------------------------
module wbc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          end_of_frame,
  output logic          in_stall,
  output wbc_pkg::cmd_t cmd,
  input  wbc_pkg::sts_t sts
);
  import wbc_pkg::*;

  state_t state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = '0;
    unique case (state)
      ST_ACCUM: begin
        if (in_valid && end_of_frame) state_next = ST_CENT;
      end
      ST_CENT: begin
        if (cnt == CENT_LAST) begin
          state_next = sts.found ? ST_OFFSET : ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_OFFSET: begin
        state_next = ST_PROD;
      end
      ST_PROD: begin
        state_next = sts.lin_ok ? ST_LIN : ST_DONE;
      end
      ST_LIN: begin
        if (cnt == LIN_LAST) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_ACCUM: begin
        in_stall = 1'b0;
        cmd.pix = in_valid;
      end
      ST_CENT: cmd.div_step = 1'b1;
      ST_OFFSET: cmd.calc_offset = 1'b1;
      ST_PROD: cmd.calc_prod = 1'b1;
      ST_LIN: cmd.div_step = 1'b1;
      ST_DONE: cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_eof_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && end_of_frame) |=> (state == ST_CENT))
    else $error("end of frame did not start the centroid division");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while output register occupied");

  a_no_pixel_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step || cmd.calc_offset || cmd.calc_prod) |-> !cmd.pix)
    else $error("pixel taken while result computation active");

endmodule

@@ src/wbc_datapath.sv @@
// ----------------------------------------------------------------------------
// wbc_datapath
// config registers, column accumulators, shared restoring divider, outputs
// ----------------------------------------------------------------------------
module wbc_datapath #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic                end_of_frame,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                ball_found,
  output logic signed [12:0]  offset_x,
  output logic [15:0]         forward_cmd,
  output logic signed [27:0]  turn_cmd,
  input  wbc_pkg::cmd_t       cmd,
  output wbc_pkg::sts_t       sts
);
  import wbc_pkg::*;

  localparam int WCAP = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam logic signed [30:0] ANG_HI = 31'sd134217727;
  localparam logic signed [30:0] ANG_LO = -31'sd134217728;

  logic [12:0] image_width;
  logic [7:0]  white_level;
  logic [15:0] angular_gain;
  logic [15:0] max_linear;

  logic [COL_W-1:0] column_count;
  logic [SUM_W-1:0] column_sum;
  logic [CNT_W-1:0] match_count;

  logic [CNT_W-1:0]  rem;
  logic [QUO_W-1:0]  quo_sh;
  logic [CNT_W-1:0]  divisor;
  logic              found;
  logic              lin_ok;
  logic signed [13:0] offset_r;
  logic [12:0]       mag;
  logic signed [30:0] ang_prod;

  logic [COL_W-1:0]  eff_w;
  logic [COL_W-1:0]  col;
  logic [COL_W:0]    col_inc;
  logic              hit;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W+1:0]  diff;
  logic [HALF_W-1:0] half;
  logic signed [13:0] off_c;
  logic [12:0]       mag_c;
  logic [27:0]       lin_prod;
  logic [27:0]       ang_sat;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= RST_IMAGE_WIDTH;
      white_level <= RST_WHITE_LEVEL;
      angular_gain <= RST_ANGULAR_GAIN;
      max_linear <= RST_MAX_LINEAR;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: image_width <= cfg_data[12:0];
        REG_WHITE_LEVEL: white_level <= cfg_data[7:0];
        REG_ANGULAR_GAIN: angular_gain <= cfg_data;
        REG_MAX_LINEAR: max_linear <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel accumulation, divider step terms and result arithmetic (combinational)
  always_comb begin
    eff_w = (32'(image_width) > WCAP) ? COL_W'(WCAP) : image_width;
    col = (eff_w == '0) ? '0 : column_count;
    col_inc = {1'b0, col} + 1'b1;
    hit = (red == white_level) && (green == white_level) && (blue == white_level) &&
          (match_count != COUNT_MAX) && (column_sum <= SUM_MAX - SUM_W'(col));
    sum_new = hit ? column_sum + SUM_W'(col) : column_sum;
    cnt_new = hit ? match_count + 1'b1 : match_count;
    half = eff_w[COL_W-1:1];
    diff = {1'b0, rem, quo_sh[QUO_W-1]} - {2'b00, divisor};
    off_c = $signed({2'b00, half}) - $signed({1'b0, quo_sh[CENT_SHIFT-1:0]});
    mag_c = off_c[13] ? 13'(-off_c) : off_c[12:0];
    lin_prod = 28'(max_linear) * 28'(half - mag[HALF_W-1:0]);
    if (ang_prod > ANG_HI) begin
      ang_sat = ANG_HI[27:0];
    end else if (ang_prod < ANG_LO) begin
      ang_sat = ANG_LO[27:0];
    end else begin
      ang_sat = ang_prod[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      column_sum <= '0;
      match_count <= '0;
    end else if (cmd.pix) begin
      if (end_of_frame) begin
        column_count <= '0;
        column_sum <= '0;
        match_count <= '0;
      end else begin
        column_count <= (col_inc >= {1'b0, eff_w}) ? '0 : col_inc[COL_W-1:0];
        column_sum <= sum_new;
        match_count <= cnt_new;
      end
    end
  end

  // shared divider and result arithmetic
  always_ff @(posedge clk) begin
    if (cmd.pix && end_of_frame) begin
      rem <= CNT_W'(sum_new[SUM_W-1:CENT_SHIFT]);
      quo_sh <= {sum_new[CENT_SHIFT-1:0], {(QUO_W-CENT_SHIFT){1'b0}}};
      divisor <= cnt_new;
      found <= (cnt_new != '0);
    end else if (cmd.div_step) begin
      rem <= diff[CNT_W+1] ? {rem[CNT_W-2:0], quo_sh[QUO_W-1]} : diff[CNT_W-1:0];
      quo_sh <= {quo_sh[QUO_W-2:0], ~diff[CNT_W+1]};
    end else if (cmd.calc_prod) begin
      rem <= CNT_W'(lin_prod[27:QUO_W]);
      quo_sh <= lin_prod[QUO_W-1:0];
      divisor <= CNT_W'(half);
    end
    if (cmd.calc_offset) begin
      offset_r <= off_c;
      mag <= mag_c;
      lin_ok <= (half != '0) && ({1'b0, half} > mag_c);
    end
    if (cmd.calc_prod) begin
      ang_prod <= 31'($signed({1'b0, angular_gain})) * 31'(offset_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ball_found <= found;
      offset_x <= found ? offset_r[12:0] : '0;
      forward_cmd <= (found && lin_ok) ? quo_sh : '0;
      turn_cmd <= found ? ang_sat : '0;
    end
  end

  always_comb begin
    sts.found = found;
    sts.lin_ok = lin_ok;
    sts.out_free = !out_valid || !out_stall;
  end

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ball_found) |->
      (offset_x == '0 && forward_cmd == '0 && turn_cmd == '0))
    else $error("empty frame result not all zeros");

  a_linear_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (forward_cmd <= max_linear))
    else $error("forward command above top speed");

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.pix && end_of_frame) |=> (match_count == '0 && column_sum == '0))
    else $error("frame accumulators not cleared after last pixel");

endmodule

@@ src/white_blob_centroid_steering_top.sv @@
// ----------------------------------------------------------------------------
// white_blob_centroid_steering_top
// one pixel per cycle within a frame; pixels update registered accumulators
// last pixel: 13 divider steps for the centroid, offset and product states,
// then 16 divider steps for the forward command, then the result is registered
// (with no white pixel only the centroid steps; forward steps skipped when the
// forward command is zero by range); input stalled until result loaded, and an
// output stall delays that; sync reset restores defaults, clears frame state
// ----------------------------------------------------------------------------
module white_blob_centroid_steering_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic               end_of_frame,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ball_found,
  output logic signed [12:0] offset_x,
  output logic [15:0]        forward_cmd,
  output logic signed [27:0] turn_cmd
);
  import wbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wbc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .end_of_frame (end_of_frame),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  wbc_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_frame (end_of_frame),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .ball_found   (ball_found),
    .offset_x     (offset_x),
    .forward_cmd  (forward_cmd),
    .turn_cmd     (turn_cmd),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
